@@ rtl/omcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package omcf_pkg;

    // Sample and result widths (unsigned Q8.8 codes)
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 17;
    localparam int OUT_TDATA_W = 24;

    // floor(x / 10) for x < 2^19 as (x * SUPP_MUL) >> SUPP_SHIFT
    localparam int                SUPP_X_W   = 19;
    localparam int                SUPP_SHIFT = 23;
    localparam int                SUPP_MUL_W = 20;
    localparam logic [SUPP_MUL_W-1:0] SUPP_MUL = 20'd838861;

    // Register map (word index taken from paddr[2])
    localparam logic REG_ENHANCE_ENABLE = 1'b0;

    // Control that travels with each beat down the pipeline
    typedef struct packed {
        logic                vld;
        logic                byp;
        logic [SAMPLE_W-1:0] smp;
    } t_beat_ctl;

endpackage

`default_nettype wire

@@ rtl/omcf_median.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Median of the window by rank counting: each entry's rank is the number of
// entries that sort ahead of it (ties broken by index), so ranks are unique.
module omcf_median
    import omcf_pkg::*;
#(
    parameter int WINDOW_LEN = 7
) (
    input  wire logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] i_win,
    output logic      [SAMPLE_W-1:0]                 o_median
);

    localparam int RANK_W = $clog2(WINDOW_LEN);
    localparam logic [RANK_W-1:0] RANK_LO = RANK_W'((WINDOW_LEN - 1) / 2);
    localparam logic [RANK_W-1:0] RANK_HI = RANK_W'(WINDOW_LEN / 2);

    logic [WINDOW_LEN-1:0][RANK_W-1:0] rank;
    logic [SAMPLE_W-1:0]               mid_lo;
    logic [SAMPLE_W-1:0]               mid_hi;
    logic [SAMPLE_W:0]                 mid_sum;

    // rank of every entry, all in parallel
    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++) begin
                if (j != i) begin
                    if ((i_win[j] < i_win[i]) || ((i_win[j] == i_win[i]) && (j < i))) begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // pick the two middle entries; they coincide for an odd length
    always_comb begin
        mid_lo = '0;
        mid_hi = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            if (rank[i] == RANK_LO) mid_lo = mid_lo | i_win[i];
            if (rank[i] == RANK_HI) mid_hi = mid_hi | i_win[i];
        end
    end

    assign mid_sum  = {1'b0, mid_lo} + {1'b0, mid_hi};
    assign o_median = mid_sum[SAMPLE_W:1];

endmodule

`default_nettype wire

@@ rtl/onset_median_contrast_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A result beat passes the stage 1, 2 and 3 registers and then the output register.
// Throughput: one beat per cycle; the pipeline stalls as a whole only while a
// result waits on m_axis_tready. Median is a parallel rank network, mean comes
// from a running window sum times a reciprocal.
// Reset (synchronous, active low) clears the window, its sum, the write index and
// the pipeline valids, and sets enhance_enable.
module onset_median_contrast_filter
    import omcf_pkg::*;
#(
    parameter int WINDOW_LEN = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] onset_sample
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // [16:0] enhanced_sample, rest zero
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);

    localparam int POS_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int MEAN_MUL_W = SUM_W + 1;
    localparam logic [63:0] MEAN_MUL_FULL =
        ((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [MEAN_MUL_W-1:0] MEAN_MUL = MEAN_MUL_W'(MEAN_MUL_FULL);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

    // configuration register
    logic r_enable;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENHANCE_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_enable <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ENHANCE_ENABLE) prdata[0] = r_enable;
    end

    // pipeline advance
    logic r_out_vld;
    logic adv;
    logic in_acc;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;

    // window, running sum and write index
    logic [SAMPLE_W-1:0] r_win [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum;
    logic [POS_W-1:0]    r_wpos;
    logic                win_wr;

    assign win_wr = in_acc && r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) r_win[i] <= '0;
            r_sum  <= '0;
            r_wpos <= '0;
        end else if (win_wr) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                if (r_wpos == POS_W'(i)) r_win[i] <= s_axis_tdata;
            end
            r_sum  <= r_sum + SUM_W'(s_axis_tdata) - SUM_W'(r_win[r_wpos]);
            r_wpos <= (r_wpos == POS_LAST) ? '0 : r_wpos + POS_W'(1);
        end
    end

    // stage 1: beat control alongside the updated window
    t_beat_ctl r_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (adv) begin
            r_s1.vld <= in_acc;
        end
        if (adv) begin
            r_s1.byp <= !r_enable;
            r_s1.smp <= s_axis_tdata;
        end
    end

    // stage 2: median and sum of the window
    logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] win_flat;
    logic [SAMPLE_W-1:0]                 median;
    t_beat_ctl                           r_s2;
    logic [SAMPLE_W-1:0]                 r_s2_med;
    logic [SUM_W-1:0]                    r_s2_sum;

    always_comb begin
        for (int i = 0; i < WINDOW_LEN; i++) win_flat[i] = r_win[i];
    end

    omcf_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .i_win    (win_flat),
        .o_median (median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (adv) begin
            r_s2.vld <= r_s1.vld;
        end
        if (adv) begin
            r_s2.byp <= r_s1.byp;
            r_s2.smp <= r_s1.smp;
            r_s2_med <= median;
            r_s2_sum <= r_sum;
        end
    end

    // stage 3: mean = floor(sum / N), suppress = floor(7 * median / 10)
    logic [SUM_W+MEAN_MUL_W-1:0]      mean_prod;
    logic [SUPP_X_W-1:0]              med_x7;
    logic [SUPP_X_W+SUPP_MUL_W-1:0]   supp_prod;
    t_beat_ctl                        r_s3;
    logic [SAMPLE_W-1:0]              r_s3_med;
    logic [SAMPLE_W-1:0]              r_s3_mean;
    logic [SAMPLE_W-1:0]              r_s3_supp;

    assign mean_prod = (SUM_W+MEAN_MUL_W)'(r_s2_sum) * (SUM_W+MEAN_MUL_W)'(MEAN_MUL);
    assign med_x7    = {r_s2_med, 3'b000} - SUPP_X_W'(r_s2_med);
    assign supp_prod = (SUPP_X_W+SUPP_MUL_W)'(med_x7) * (SUPP_X_W+SUPP_MUL_W)'(SUPP_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else if (adv) begin
            r_s3.vld <= r_s2.vld;
        end
        if (adv) begin
            r_s3.byp  <= r_s2.byp;
            r_s3.smp  <= r_s2.smp;
            r_s3_med  <= r_s2_med;
            r_s3_mean <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
            r_s3_supp <= supp_prod[SUPP_SHIFT +: SAMPLE_W];
        end
    end

    // stage 4: boost or suppress, or pass the sample through
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W+1:0] diff_x3;
    logic [OUT_W-1:0]    n_out;
    logic [OUT_W-1:0]    r_out;

    assign diff    = r_s3_med - r_s3_mean;
    assign diff_x3 = {1'b0, diff, 1'b0} + (SAMPLE_W+2)'(diff);

    always_comb begin
        if (r_s3.byp) begin
            n_out = OUT_W'(r_s3.smp);
        end else if (r_s3_med > r_s3_mean) begin
            n_out = OUT_W'(r_s3_mean) + diff_x3[SAMPLE_W+1:1];
        end else begin
            n_out = OUT_W'(r_s3_supp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s3.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_out};

endmodule

`default_nettype wire

@@ rtl/omcf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module omcf_checker
    import omcf_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   psel,
    input wire logic                   penable,
    input wire logic                   pwrite,
    input wire logic [2:0]             paddr,
    input wire logic [31:0]            pwdata,
    input wire logic [31:0]            prdata,
    input wire logic                   pready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed under stall");

    // input side stalls exactly when a result waits
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // nothing valid right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // a written enable reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2]
        |=> (paddr[2] || (prdata[0] == $past(pwdata[0]))))
        else $error("enable register does not read back written value");

endmodule

bind onset_median_contrast_filter omcf_checker u_omcf_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import omcf_pkg::*;

    localparam int TAPS         = 7;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 40;
    localparam int ENABLE_REG   = int'(REG_ENHANCE_ENABLE);
    localparam int SPARE_REG    = 1;   // first index past the register map

    // Predicts the enhanced sample stream and holds the results still owed by the block
    class onset_scoreboard;
        logic [SAMPLE_W-1:0] window [TAPS];
        int unsigned         wr_pos;
        bit                  enable;
        logic [OUT_W-1:0]    pending [$];
        int unsigned         errors;
        int unsigned         checked;

        function new();
            foreach (window[k]) window[k] = '0;
            wr_pos  = 0;
            enable  = 1'b1;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(int unsigned idx, logic [31:0] val);
            if (idx == ENABLE_REG) enable = val[0];
        endfunction

        // Window update, median/mean and the boost or suppress rule, or pass-through when disabled
        function logic [OUT_W-1:0] enhance(logic [SAMPLE_W-1:0] smp);
            logic [SAMPLE_W-1:0] sorted [TAPS];
            logic [SAMPLE_W-1:0] key;
            int unsigned         i, j;
            int unsigned         total, median, mean, res;
            if (!enable) return {1'b0, smp};
            window[wr_pos] = smp;
            wr_pos = (wr_pos == TAPS - 1) ? 0 : wr_pos + 1;
            sorted = window;
            for (i = 1; i < TAPS; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            if (TAPS % 2 == 1) median = sorted[TAPS/2];
            else median = (sorted[TAPS/2-1] + sorted[TAPS/2]) / 2;
            total = 0;
            foreach (window[k]) total += window[k];
            mean = total / TAPS;
            if (median > mean) res = mean + (3 * (median - mean)) / 2;
            else res = (7 * median) / 10;
            return res[OUT_W-1:0];
        endfunction

        function void note_input(logic [SAMPLE_W-1:0] smp);
            pending.push_back(enhance(smp));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] beat);
            logic [OUT_W-1:0] want;
            if (pending.size() == 0) begin
                report($sformatf("result beat 0x%06h with nothing expected", beat));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (beat[OUT_W-1:0] !== want)
                report($sformatf("result %0d: enhanced_sample 0x%05h, expected 0x%05h",
                                 checked, beat[OUT_W-1:0], want));
            if (beat[OUT_TDATA_W-1:OUT_W] !== '0)
                report($sformatf("result %0d: tdata padding 0x%02h not zero",
                                 checked, beat[OUT_TDATA_W-1:OUT_W]));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata  = '0;   // [15:0] onset_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [16:0] enhanced_sample, rest zero
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [2:0]             paddr         = '0;
    logic [31:0]            pwdata        = '0;
    logic [31:0]            prdata;
    logic                   pready;

    onset_scoreboard sb;

    int unsigned tx_gap_max = 0;
    int unsigned rx_gap_max = 0;
    bit          tx_burst   = 1'b0;
    bit          hold_rx    = 1'b0;
    logic [15:0] level      = 16'h4000;

    int unsigned n_sent  = 0;
    int unsigned n_enh   = 0;
    int unsigned n_pass  = 0;
    int unsigned n_cfg   = 0;
    int unsigned n_stall = 0;
    int unsigned quiet   = 0;

    onset_median_contrast_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on cycles without any accepted beat or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (s_axis_tvalid && !s_axis_tready) n_stall++;
        if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One input beat; tvalid stays high across back-to-back beats
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int unsigned gap;
        if (n_sent % 32 == 0) tx_gap_max = $urandom_range(0, 1) ? 15 : 0;
        gap = tx_burst ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        if (sb.enable) n_enh++;
        else n_pass++;
        sb.note_input(smp);
        n_sent++;
    endtask

    // Result side: random gaps, plus one long hold-off on request
    task automatic run_receiver();
        int unsigned gap;
        int unsigned cnt;
        cnt = 0;
        forever begin
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            if (cnt % 32 == 0) rx_gap_max = $urandom_range(0, 1) ? 15 : 0;
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
            cnt++;
        end
    endtask

    // Setup and access phases, then back to idle on the bus
    task automatic apb_write(input int unsigned idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
        n_cfg++;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input int unsigned idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= 3'(idx * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {31'b0, sb.enable})
            sb.report($sformatf("enhance_enable read 0x%08h, expected %0d", prdata, sb.enable));
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg++;
        @(posedge i_clk);
    endtask

    // Stop offering, let every expected result arrive, then cover the pipeline depth
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Mix of uniform codes, extremes, and steady levels with dropouts to hit both rules
    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 11))
            0, 1, 2: return 16'($urandom);
            3:       return 16'($urandom_range(0, 255));
            4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            5:       return 16'($urandom_range(65000, 65535));
            6: begin
                level = 16'($urandom);
                return level;
            end
            default: begin
                if ($urandom_range(0, 5) == 0) return 16'h0000;
                v = int'(level) + int'($urandom_range(0, 512)) - 256;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    logic [15:0] directed [21] = '{
        16'h0100,
        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000, 16'h0000,
        16'h0001, 16'h0002, 16'h0003,
        16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'hFFFE, 16'h0001,
        16'h0000
    };
    int          plan [6] = '{1, 0, 1, 1, 0, 1};

    initial begin
        int unsigned count;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork
            run_receiver();
        join_none

        // Reset value, then zero-filled window start, saturation and boost/suppress corners
        apb_read_check(ENABLE_REG);
        foreach (directed[k]) send_sample(directed[k]);
        drain();

        // Pass-through leaves the window alone; a write past the map is ignored
        apb_write(ENABLE_REG, 32'hFFFF_FFFE);
        apb_read_check(ENABLE_REG);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h1234);
        drain();
        apb_write(SPARE_REG, 32'h0000_0001);
        apb_read_check(ENABLE_REG);
        send_sample(16'hFFFF);
        drain();

        for (int p = 0; p < 6; p++) begin
            if (p == 3) apb_write(SPARE_REG, $urandom);
            apb_write(ENABLE_REG, ($urandom & 32'hFFFF_FFFE) | 32'(plan[p]));
            apb_read_check(ENABLE_REG);
            count = plan[p] ? 380 : 180;
            if (p == 2) begin
                // Long output stall while the input keeps pushing
                tx_burst = 1'b1;
                hold_rx  = 1'b1;
                for (int k = 0; k < 80; k++) send_sample(pick_sample());
                tx_burst = 1'b0;
                count -= 80;
            end
            for (int k = 0; k < count; k++) send_sample(pick_sample());
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending.size()));
        $display("Covered %0d samples (%0d enhanced, %0d passed through), %0d register accesses",
                 n_sent, n_enh, n_pass, n_cfg);
        $display("Checked %0d results; input held off for %0d cycles by output backpressure",
                 sb.checked, n_stall);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
